[rtl/eqc_pkg.sv]
// Package for the ECG QRS feature chain: constants, command and status types,
// and the biquad coefficient table. No dependencies.
package eqc_pkg;

	localparam int STAGES      = 6;
	localparam int Q_SHIFT     = 10;
	localparam int DERIV_SHIFT = 3;
	localparam int SQ_SHIFT    = 8;
	localparam int BP_DIVISOR  = 90;

	localparam logic [2:0] TAP_X0 = 3'd0;
	localparam logic [2:0] TAP_X1 = 3'd1;
	localparam logic [2:0] TAP_X2 = 3'd2;
	localparam logic [2:0] TAP_Y1 = 3'd3;
	localparam logic [2:0] TAP_Y2 = 3'd4;

	localparam logic [2:0] LAST_TAP   = TAP_Y2;
	localparam logic [2:0] LAST_STAGE = 3'(STAGES - 1);

	typedef enum logic {
		DIV_BP,
		DIV_EN
	} eqc_div_sel_t;

	typedef struct packed {
		logic         load_in;
		logic         mul;
		logic         upd;
		logic         div_start;
		eqc_div_sel_t div_sel;
		logic         deriv;
		logic         sq_mul;
		logic         win;
		logic         load_out;
		logic [2:0]   stage;
		logic [2:0]   tap;
	} eqc_cmd_t;

	typedef struct packed {
		logic div_busy;
	} eqc_status_t;

	function automatic logic signed [11:0] coef(input logic [2:0] stage, input logic [2:0] tap);
		logic signed [11:0] b1;
		logic signed [11:0] a1;
		logic signed [11:0] a2;
		logic signed [11:0] c;
		case (stage)
			3'd0: begin b1 = -12'sd1857; a1 = -12'sd1881; a2 = 12'sd981;  end
			3'd1: begin b1 = -12'sd2036; a1 = -12'sd2013; a2 = 12'sd1007; end
			3'd2: begin b1 = -12'sd1463; a1 = -12'sd1878; a2 = 12'sd928;  end
			3'd3: begin b1 = -12'sd2044; a1 = -12'sd1957; a2 = 12'sd963;  end
			3'd4: begin b1 = -12'sd1888; a1 = -12'sd1896; a2 = 12'sd1015; end
			default: begin b1 = -12'sd2034; a1 = -12'sd2029; a2 = 12'sd1021; end
		endcase
		case (tap)
			TAP_X1: c = b1;
			TAP_Y1: c = a1;
			TAP_Y2: c = a2;
			default: c = 12'sd1024;
		endcase
		return c;
	endfunction

endpackage

[rtl/eqc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module eqc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/eqc_div.sv]
// Reciprocal-multiply divider, signed 32-bit dividend by one of two constant
// divisors, quotient truncated toward zero. Depends on eqc_pkg.
module eqc_div #(
	parameter int WINDOW_LENGTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  eqc_pkg::eqc_div_sel_t sel,
	input  logic [31:0]          dividend,
	output logic                 busy,
	output logic [31:0]          quotient
);
	import eqc_pkg::*;

	localparam int BP_K = 31 + $clog2(BP_DIVISOR);
	localparam int WL_K = 31 + $clog2(WINDOW_LENGTH);
	localparam logic [63:0] BP_M64 =
		((64'd1 << BP_K) + 64'(BP_DIVISOR) - 64'd1) / 64'(BP_DIVISOR);
	localparam logic [63:0] WL_M64 =
		((64'd1 << WL_K) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH);
	localparam logic [31:0] BP_M = BP_M64[31:0];
	localparam logic [31:0] WL_M = WL_M64[31:0];

	logic [1:0]  cnt_q;
	logic [31:0] mag_q;
	logic [31:0] mult_q;
	logic        wl_q;
	logic        neg_q;
	logic [63:0] prod_q;
	logic [31:0] quot_q;
	logic [31:0] mag;

	assign busy     = cnt_q != 2'd0;
	assign quotient = quot_q;
	assign mag      = wl_q ? 32'(prod_q >> WL_K) : 32'(prod_q >> BP_K);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (start) begin
			cnt_q <= 2'd2;
		end else if (busy) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q  <= dividend[31] ? (~dividend + 32'd1) : dividend;
			mult_q <= (sel == DIV_EN) ? WL_M : BP_M;
			wl_q   <= sel == DIV_EN;
			neg_q  <= dividend[31];
		end
		if (cnt_q == 2'd2) begin
			prod_q <= 64'(mag_q) * 64'(mult_q);
		end
		if (cnt_q == 2'd1) begin
			quot_q <= neg_q ? (~mag + 32'd1) : mag;
		end
	end

endmodule

[rtl/eqc_datapath.sv]
// Datapath: biquad histories, shared multiplier and accumulator, derivative,
// window sum over a circular RAM, shared divider and output registers.
// Depends on eqc_pkg, eqc_ram and eqc_div.
module eqc_datapath #(
	parameter int WINDOW_LENGTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  eqc_pkg::eqc_cmd_t     cmd,
	output eqc_pkg::eqc_status_t  status,
	input  logic [23:0]           sample,
	output logic [31:0]           bandpassed,
	output logic [31:0]           slope,
	output logic [31:0]           energy
);
	import eqc_pkg::*;

	localparam int PTR_W = $clog2(WINDOW_LENGTH);

	logic [31:0] xh_q [2*STAGES];
	logic [31:0] yh_q [2*STAGES];
	logic [31:0] sh_q [4];
	logic [31:0] x_cur_q;
	logic [31:0] acc_q;
	logic [31:0] prod_s1;
	logic        prod_vld_s1;
	logic        prod_sub_s1;
	logic        prod_first_s1;
	logic [31:0] bp_q;
	logic [31:0] sl_q;
	logic [31:0] sum_q;
	logic [31:0] total_q;
	logic [PTR_W-1:0] ptr_q;
	logic        full_q;

	logic [3:0]  idx0;
	logic [3:0]  idx1;
	logic [31:0] op;
	logic [31:0] coef32;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [31:0] acc_base;
	logic [31:0] y;
	logic [31:0] deriv_sum;
	logic [31:0] sl_new;
	logic [31:0] sq;
	logic [31:0] old;
	logic [31:0] ram_rd;
	logic [31:0] div_dividend;
	logic [31:0] div_res;
	logic        div_busy;

	assign idx0   = {cmd.stage, 1'b0};
	assign idx1   = {cmd.stage, 1'b1};
	assign coef32 = 32'(coef(cmd.stage, cmd.tap));

	always_comb begin
		case (cmd.tap)
			TAP_X0: op = x_cur_q;
			TAP_X1: op = xh_q[idx0];
			TAP_X2: op = xh_q[idx1];
			TAP_Y1: op = yh_q[idx0];
			TAP_Y2: op = yh_q[idx1];
			default: op = x_cur_q;
		endcase
	end

	assign mul_a    = cmd.sq_mul ? sl_q : coef32;
	assign mul_b    = cmd.sq_mul ? sl_q : op;
	assign acc_base = prod_first_s1 ? 32'd0 : acc_q;
	assign y        = 32'($signed(acc_q) >>> Q_SHIFT);

	assign deriv_sum = {div_res[30:0], 1'b0} + sh_q[0] - sh_q[2] - {sh_q[3][30:0], 1'b0};
	assign sl_new    = 32'($signed(deriv_sum) >>> DERIV_SHIFT);
	assign sq        = 32'($signed(prod_s1) >>> SQ_SHIFT);
	assign old       = full_q ? ram_rd : 32'd0;

	assign div_dividend = (cmd.div_sel == DIV_BP) ? x_cur_q : total_q;
	assign status.div_busy = div_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2*STAGES; i++) begin
				xh_q[i] <= '0;
				yh_q[i] <= '0;
			end
			for (int i = 0; i < 4; i++) begin
				sh_q[i] <= '0;
			end
			prod_vld_s1 <= 1'b0;
			sum_q       <= '0;
			ptr_q       <= '0;
			full_q      <= 1'b0;
		end else begin
			prod_vld_s1 <= cmd.mul;
			if (cmd.upd) begin
				xh_q[idx1] <= xh_q[idx0];
				xh_q[idx0] <= x_cur_q;
				yh_q[idx1] <= yh_q[idx0];
				yh_q[idx0] <= y;
			end
			if (cmd.deriv) begin
				sh_q[3] <= sh_q[2];
				sh_q[2] <= sh_q[1];
				sh_q[1] <= sh_q[0];
				sh_q[0] <= div_res;
			end
			if (cmd.win) begin
				sum_q <= sum_q - old + sq;
				if (ptr_q == PTR_W'(WINDOW_LENGTH - 1)) begin
					ptr_q  <= '0;
					full_q <= 1'b1;
				end else begin
					ptr_q <= ptr_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			x_cur_q <= {{8{sample[23]}}, sample};
		end else if (cmd.upd) begin
			x_cur_q <= y;
		end
		if (cmd.mul || cmd.sq_mul) begin
			prod_s1 <= mul_a * mul_b;
		end
		prod_sub_s1   <= (cmd.tap == TAP_Y1) || (cmd.tap == TAP_Y2);
		prod_first_s1 <= cmd.tap == TAP_X0;
		if (prod_vld_s1) begin
			acc_q <= prod_sub_s1 ? (acc_base - prod_s1) : (acc_base + prod_s1);
		end
		if (cmd.deriv) begin
			bp_q <= div_res;
			sl_q <= sl_new;
		end
		if (cmd.win) begin
			total_q <= sq + sum_q;
		end
		if (cmd.load_out) begin
			bandpassed <= bp_q;
			slope      <= sl_q;
			energy     <= div_res;
		end
	end

	eqc_ram #(
		.WIDTH(32),
		.DEPTH(WINDOW_LENGTH)
	) u_window (
		.clk  (clk),
		.we   (cmd.win),
		.waddr(ptr_q),
		.wdata(sq),
		.raddr(ptr_q),
		.rdata(ram_rd)
	);

	eqc_div #(
		.WINDOW_LENGTH(WINDOW_LENGTH)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.sel     (cmd.div_sel),
		.dividend(div_dividend),
		.busy    (div_busy),
		.quotient(div_res)
	);

endmodule

[rtl/eqc_ctrl.sv]
// Controller state machine sequencing the biquad MACs, divisions, derivative,
// window update and the input and output handshakes. Depends on eqc_pkg.
module eqc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	output logic                  out_valid,
	input  logic                  out_stall,
	output eqc_pkg::eqc_cmd_t     cmd,
	input  eqc_pkg::eqc_status_t  status
);
	import eqc_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MAC,
		ST_FIN,
		ST_UPD,
		ST_BPDIV,
		ST_BPWAIT,
		ST_SQMUL,
		ST_WIN,
		ST_ENDIV,
		ST_ENWAIT,
		ST_OUT
	} state_t;

	state_t     state_q;
	logic [2:0] stage_q;
	logic [2:0] tap_q;
	logic       out_valid_q;
	logic       out_free;

	assign in_stall  = state_q != ST_IDLE;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		cmd           = '0;
		cmd.stage     = stage_q;
		cmd.tap       = tap_q;
		cmd.div_sel   = DIV_BP;
		case (state_q)
			ST_IDLE:   cmd.load_in = in_valid;
			ST_MAC:    cmd.mul = 1'b1;
			ST_UPD:    cmd.upd = 1'b1;
			ST_BPDIV:  cmd.div_start = 1'b1;
			ST_BPWAIT: cmd.deriv = !status.div_busy;
			ST_SQMUL:  cmd.sq_mul = 1'b1;
			ST_WIN:    cmd.win = 1'b1;
			ST_ENDIV: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_EN;
			end
			ST_OUT:    cmd.load_out = out_free;
			default:   cmd.load_in = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			stage_q     <= '0;
			tap_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						stage_q <= '0;
						tap_q   <= TAP_X0;
						state_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					if (tap_q == LAST_TAP) begin
						state_q <= ST_FIN;
					end else begin
						tap_q <= tap_q + 3'd1;
					end
				end
				ST_FIN: state_q <= ST_UPD;
				ST_UPD: begin
					tap_q <= TAP_X0;
					if (stage_q == LAST_STAGE) begin
						state_q <= ST_BPDIV;
					end else begin
						stage_q <= stage_q + 3'd1;
						state_q <= ST_MAC;
					end
				end
				ST_BPDIV: state_q <= ST_BPWAIT;
				ST_BPWAIT: begin
					if (!status.div_busy) begin
						state_q <= ST_SQMUL;
					end
				end
				ST_SQMUL: state_q <= ST_WIN;
				ST_WIN:   state_q <= ST_ENDIV;
				ST_ENDIV: state_q <= ST_ENWAIT;
				ST_ENWAIT: begin
					if (!status.div_busy) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[rtl/ecg_qrs_feature_chain_top.sv]
// A sample is accepted only while the controller is idle, so a transaction completes before
// the next one starts; the six biquads run in turn on one shared multiplier and the
// bandpass and energy results take two passes of the reciprocal divider.
// A waiting result does not block the next transaction until the following result is due.
// Reset clears all filter, derivative and window history and the handshake state at once.
// Top level of the QRS feature chain; depends on eqc_pkg, eqc_ctrl and eqc_datapath.
module ecg_qrs_feature_chain_top #(
	parameter int WINDOW_LENGTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [23:0] sample,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] bandpassed,
	output logic signed [31:0] slope,
	output logic signed [31:0] energy
);
	import eqc_pkg::*;

	eqc_cmd_t    cmd;
	eqc_status_t status;

	eqc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd      (cmd),
		.status   (status)
	);

	eqc_datapath #(
		.WINDOW_LENGTH(WINDOW_LENGTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.sample    (sample),
		.bandpassed(bandpassed),
		.slope     (slope),
		.energy    (energy)
	);

`ifndef NO_ASSERTIONS
	a_accept_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while a transaction was in progress");

	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a transaction in progress");

	a_div_not_busy_at_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !status.div_busy)
		else $error("divider started while busy");
`endif

endmodule

[dv/testbench.sv]
// Self-checking testbench for the ECG QRS feature chain top level.
// Drives samples with random idling, predicts each result and compares it field by field.
// Depends on eqc_pkg and ecg_qrs_feature_chain_top.
class qrs_scoreboard;
	logic [31:0] sec_x[12];
	logic [31:0] sec_y[12];
	logic [31:0] bp_hist[4];
	logic [31:0] sq_win[32];
	logic [31:0] exp_bp[$];
	logic [31:0] exp_sl[$];
	logic [31:0] exp_en[$];
	int errors;

	function new();
		foreach (sec_x[i]) begin
			sec_x[i] = 0;
			sec_y[i] = 0;
		end
		foreach (bp_hist[i]) bp_hist[i] = 0;
		foreach (sq_win[i]) sq_win[i] = 0;
		errors = 0;
	endfunction

	function void note_sample(logic [23:0] smp);
		logic signed [31:0] x;
		logic signed [31:0] acc;
		logic signed [31:0] bp;
		logic signed [31:0] sl;
		logic signed [31:0] sq;
		logic signed [31:0] b1[6];
		logic signed [31:0] a1[6];
		logic signed [31:0] a2[6];
		b1 = '{-1857, -2036, -1463, -2044, -1888, -2034};
		a1 = '{-1881, -2013, -1878, -1957, -1896, -2029};
		a2 = '{981, 1007, 928, 963, 1015, 1021};
		x = {{8{smp[23]}}, smp};
		for (int s = 0; s < 6; s++) begin
			acc = 1024 * x + b1[s] * $signed(sec_x[2*s]) + 1024 * $signed(sec_x[2*s+1])
				- a1[s] * $signed(sec_y[2*s]) - a2[s] * $signed(sec_y[2*s+1]);
			acc = acc >>> 10;
			sec_y[2*s+1] = sec_y[2*s];
			sec_y[2*s] = acc;
			sec_x[2*s+1] = sec_x[2*s];
			sec_x[2*s] = x;
			x = acc;
		end
		bp = x / 90;
		acc = 2 * bp + $signed(bp_hist[0]) - $signed(bp_hist[2]) - 2 * $signed(bp_hist[3]);
		sl = acc >>> 3;
		for (int i = 3; i > 0; i--) bp_hist[i] = bp_hist[i-1];
		bp_hist[0] = bp;
		acc = sl * sl;
		sq = acc >>> 8;
		acc = sq;
		for (int i = 31; i > 0; i--) begin
			acc = acc + $signed(sq_win[i]);
			sq_win[i] = sq_win[i-1];
		end
		acc = acc + $signed(sq_win[0]);
		sq_win[0] = sq;
		exp_bp.push_back(bp);
		exp_sl.push_back(sl);
		exp_en.push_back(acc / 32);
	endfunction

	task report(string what, logic [31:0] got, logic [31:0] want);
		$display("Mismatch on %s: got %0d, expected %0d", what, $signed(got), $signed(want));
		errors++;
	endtask

	task check_result(logic [31:0] bp, logic [31:0] sl, logic [31:0] en);
		if (exp_bp.size() == 0) begin
			report("unexpected result transaction, bandpassed", bp, 32'd0);
		end else begin
			if (bp !== exp_bp[0]) report("bandpassed", bp, exp_bp[0]);
			if (sl !== exp_sl[0]) report("slope", sl, exp_sl[0]);
			if (en !== exp_en[0]) report("energy", en, exp_en[0]);
			void'(exp_bp.pop_front());
			void'(exp_sl.pop_front());
			void'(exp_en.pop_front());
		end
	endtask
endclass

module testbench;
	import eqc_pkg::*;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic signed [23:0] sample = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] bandpassed;
	logic signed [31:0] slope;
	logic signed [31:0] energy;

	qrs_scoreboard sb = new();
	bit calm = 1'b0;
	bit hold_off = 1'b0;
	bit stim_done = 1'b0;

	ecg_qrs_feature_chain_top u_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.sample(sample), .out_valid(out_valid), .out_stall(out_stall),
		.bandpassed(bandpassed), .slope(slope), .energy(energy)
	);

	always #10 clk = ~clk;

	task send_sample(logic [23:0] v);
		while (!calm && $urandom_range(99) < 26) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= v;
		do @(posedge clk); while (in_stall);
		sb.note_sample(v);
	endtask

	function automatic logic [23:0] rand_sample();
		case ($urandom_range(5))
			0: return 24'($urandom);
			1: return 24'(24'h7FFFFF - $urandom_range(3));
			2: return 24'(24'h800000 + $urandom_range(3));
			default: return 24'($signed($urandom_range(20000)) - 10000);
		endcase
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) sb.check_result(bandpassed, slope, energy);
			out_stall <= hold_off || (!calm && $urandom_range(99) < 26);
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_sample(24'h000000);
		send_sample(24'h7FFFFF);
		send_sample(24'h800000);
		send_sample(24'h7FFFFF);
		send_sample(24'h800000);
		send_sample(24'hFFFFFF);
		send_sample(24'h000001);
		send_sample(24'h555555);
		send_sample(24'hAAAAAA);
		for (int i = 0; i < 8; i++) send_sample(i[0] ? 24'h7FFFFF : 24'h800000);
		in_valid <= 1'b0;
		while (sb.exp_bp.size() != 0) @(posedge clk);
		hold_off = 1'b1;
		fork
			begin
				repeat (800) @(posedge clk);
				hold_off = 1'b0;
			end
			for (int i = 0; i < 6; i++) send_sample(rand_sample());
		join
		for (int i = 0; i < 1900; i++) begin
			calm = (i >= 600 && i < 800);
			send_sample(rand_sample());
		end
		in_valid <= 1'b0;
		calm = 1'b0;
		while (sb.exp_bp.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.errors == 0 && sb.exp_bp.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#12000000;
		$display("Verification failed");
		$finish;
	end
endmodule

[sim.f]
rtl/eqc_pkg.sv
rtl/eqc_ram.sv
rtl/eqc_div.sv
rtl/eqc_datapath.sv
rtl/eqc_ctrl.sv
rtl/ecg_qrs_feature_chain_top.sv
dv/testbench.sv
